/* sv/crv_pkg.sv */
// ----------------------------------------------------------------------------
// crv_pkg - shared types and constants for the CORDIC rotate/vector block
// Datapath width, stage count, arctangent table (degrees * 2^22) and
// conversions between the 32-bit port words and the internal datapath.
// ----------------------------------------------------------------------------
package crv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ITERATIONS = 29;
    localparam int TABLE_LEN  = 29;
    localparam int PORT_WIDTH = 32;
    localparam int SHIFT_W    = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    localparam logic CMD_VECTOR = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [PORT_WIDTH-1:0] t_port;
    typedef logic        [SHIFT_W-1:0]    t_shift;

    typedef struct packed {
        logic valid;
        logic cmd;
    } t_tag;

    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
        32'd7507429,   32'd3754631,   32'd1877430,  32'd938729,   32'd469366,
        32'd234683,    32'd117342,    32'd58671,    32'd29335,    32'd14668,
        32'd7334,      32'd3667,      32'd1833,     32'd917,      32'd458,
        32'd229,       32'd115,       32'd57,       32'd29,       32'd14,
        32'd7,         32'd4,         32'd2,        32'd1
    };

    // table entry wrapped or zero-extended to the datapath width
    function automatic t_data atan_at(input int idx);
        logic [63:0] wide;
        wide = 64'(ATAN_TABLE[idx]);
        return t_data'(wide[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_data port_to_data(input t_port v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return t_data'(wide[DATA_WIDTH-1:0]);
    endfunction

    function automatic t_port data_to_port(input t_data v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return t_port'(wide[PORT_WIDTH-1:0]);
    endfunction

endpackage

/* sv/crv_cell.sv */
// ----------------------------------------------------------------------------
// crv_cell - one CORDIC micro-rotation stage
// Shift-add step on x, y and z, steered by sign of y (vectoring) or z
// (rotation); registers the word and its tag when the stage loads.
// ----------------------------------------------------------------------------
module crv_cell
    import crv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_shift i_shift,
    input  t_data  i_atan,
    input  t_tag   i_tag,
    input  t_data  i_x,
    input  t_data  i_y,
    input  t_data  i_z,
    output t_tag   o_tag,
    output t_data  o_x,
    output t_data  o_y,
    output t_data  o_z
);

    logic  r_valid;
    logic  r_cmd;
    t_data r_x, r_y, r_z;
    t_data n_x, n_y, n_z;
    t_data w_xs, w_ys;
    logic  w_plus;

    always_comb begin
        w_xs   = i_x >>> i_shift;
        w_ys   = i_y >>> i_shift;
        w_plus = (i_tag.cmd == CMD_ROTATE) ? i_z[DATA_WIDTH-1] : !i_y[DATA_WIDTH-1];
        if (w_plus) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + i_atan;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_tag.cmd;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

    assign o_tag.valid = r_valid;
    assign o_tag.cmd   = r_cmd;
    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_z         = r_z;

endmodule

/* sv/cordic_rotate_and_vector.sv */
// Circular CORDIC, rotation (cmd=1) and vectoring (cmd=0), on signed values
// scaled by 2^22 with angles in degrees * 2^22. One word enters per cycle
// while the input is not stalled; a word's result passes through the chain
// of 29 registered micro-rotation stages, the last of which is the
// output register. Results are raw (gain about 1.6468, no compensation) and
// wrap modulo 2^32. Output stall holds only full stages: empty stages keep
// loading, so the input keeps accepting until the whole chain is full.
// ----------------------------------------------------------------------------
// cordic_rotate_and_vector - pipelined CORDIC rotate/vector top level
// Chain of crv_cell stages with per-stage valid and a load chain that
// collapses bubbles under output stall.
// ----------------------------------------------------------------------------
module cordic_rotate_and_vector
    import crv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_cmd,
    input  t_port i_x_in,
    input  t_port i_y_in,
    input  t_port i_z_in,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_port o_x_out,
    output t_port o_y_out,
    output t_port o_z_out
);

    t_tag  w_tag [ITERATIONS+1];
    t_data w_x   [ITERATIONS+1];
    t_data w_y   [ITERATIONS+1];
    t_data w_z   [ITERATIONS+1];
    logic  [ITERATIONS-1:0] w_load;
    logic  [ITERATIONS-1:0] w_valid;

    assign w_tag[0].valid = i_in_valid;
    assign w_tag[0].cmd   = i_cmd;
    assign w_x[0]         = port_to_data(i_x_in);
    assign w_y[0]         = port_to_data(i_y_in);
    assign w_z[0]         = port_to_data(i_z_in);

    // stage loads when empty or when the stage after it moves on
    assign w_load[ITERATIONS-1] = !w_tag[ITERATIONS].valid || !i_out_stall;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
        if (k < ITERATIONS - 1) begin : g_ld
            assign w_load[k] = !w_tag[k+1].valid || w_load[k+1];
        end

        assign w_valid[k] = w_tag[k+1].valid;

        crv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[k]),
            .i_shift (t_shift'(k)),
            .i_atan  (atan_at(k)),
            .i_tag   (w_tag[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .o_tag   (w_tag[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    assign o_in_stall  = !w_load[0];
    assign o_out_valid = w_tag[ITERATIONS].valid;
    assign o_x_out     = data_to_port(w_x[ITERATIONS]);
    assign o_y_out     = data_to_port(w_y[ITERATIONS]);
    assign o_z_out     = data_to_port(w_z[ITERATIONS]);

`ifndef SYNTH
    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(w_valid) ==
            $past($countones(w_valid)) + $past(int'(w_in_acc)) - $past(int'(w_out_acc)))
        else $error("stage occupancy does not match accepted words");

    a_first_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_valid[0] && i_out_stall && o_out_valid))
        else $error("input stalled while chain can advance");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(w_z[ITERATIONS])))
        else $error("stalled result lost");
`endif

endmodule
